/* rtl/twtp_pkg.sv */
package twtp_pkg;

  // Wheel and pool geometry (SLOTS must be a power of two)
  localparam int SLOTS  = 64;
  localparam int TIMERS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(TIMERS);

  // Fixed field widths
  localparam int REQ_W      = 2;
  localparam int TIMEOUT_W  = 32;
  localparam int HANDLE_W   = 6;
  localparam int TAG_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int SI_W       = 16;

  // Divider sizing
  localparam int DIV_STEPS = TIMEOUT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_SLOT_INTERVAL = 3'd0;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_REFRESH = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK_NONE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BAD       = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic add_start;
    logic add_step;
    logic add_commit;
    logic imm_commit;
    logic tick_start;
    logic scan_step;
    logic tick_commit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             neg;
    logic             add_done;
    logic             match;
    logic             pend_valid;
    logic             scan_last;
    logic             out_free;
  } dp_stat_t;

endpackage

/* rtl/timing_wheel_timer_pool_core.sv */
// Single-level timing wheel with a pool of 64 timers and 64 slots. Requests are add,
// delete, tick and refresh; each is taken only while no other request is in progress
// and the output register can take a result. Delete, refresh and a negative-timeout
// add finish in the accept cycle and their result sits in the output register from
// the next cycle on. For a valid add, a restoring divider works out timeout /
// slot_interval one quotient bit per cycle while the free-handle search walks the
// valid bits alongside it, one entry per cycle; when the lowest free handle is below
// 32 the divider sets the length of the add, else the search does (at most the full
// pool). A tick walks every pool entry through the slot and tag memories, one entry
// per cycle while no waiting expiry is held by a stalled output.
// Timeouts wrap at 64 ticks; slot_interval 0 behaves as 1.
module timing_wheel_timer_pool_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [twtp_pkg::PADDR_W-1:0]           paddr,
  input  logic [twtp_pkg::PDATA_W-1:0]           pwdata,
  output logic [twtp_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [twtp_pkg::REQ_W-1:0]             req_type,
  input  logic signed [twtp_pkg::TIMEOUT_W-1:0]  timeout,
  input  logic [twtp_pkg::HANDLE_W-1:0]          timer_handle,
  input  logic [twtp_pkg::TAG_W-1:0]             user_tag,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [twtp_pkg::STATUS_W-1:0]          status,
  output logic [twtp_pkg::HANDLE_W-1:0]          handle_out,
  output logic [twtp_pkg::TAG_W-1:0]             tag_out,
  output logic [twtp_pkg::SLOT_OUT_W-1:0]        slot_out,
  output logic                                   last
);

  twtp_pkg::ctl_cmd_t cmd;
  twtp_pkg::dp_stat_t st;

  assign pready = 1'b1;

  twtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  twtp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .req_type     (req_type),
    .timeout      (timeout),
    .timer_handle (timer_handle),
    .user_tag     (user_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .handle_out   (handle_out),
    .tag_out      (tag_out),
    .slot_out     (slot_out),
    .last         (last),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

/* rtl/twtp_ram.sv */
module twtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/twtp_ctrl.sv */
module twtp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  twtp_pkg::dp_stat_t  st,
  output twtp_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_ADD        = 6'b000010,
    S_ADD_OUT    = 6'b000100,
    S_TICK_FIRST = 6'b001000,
    S_SCAN       = 6'b010000,
    S_TICK_END   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = !((state == S_IDLE) && st.out_free);

  // Sequence each request
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && st.out_free) begin
          case (st.req)
            twtp_pkg::REQ_ADD: begin
              if (st.neg) begin
                cmd.imm_commit = 1'b1;
              end else begin
                cmd.add_start = 1'b1;
                state_next = S_ADD;
              end
            end
            twtp_pkg::REQ_TICK: begin
              cmd.tick_start = 1'b1;
              state_next = S_TICK_FIRST;
            end
            default: cmd.imm_commit = 1'b1;
          endcase
        end
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (st.add_done) begin
          state_next = S_ADD_OUT;
        end
      end
      S_ADD_OUT: begin
        if (st.out_free) begin
          cmd.add_commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK_FIRST: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // hold while an older expiry still waits for the output register
        cmd.scan_step = !(st.match && st.pend_valid && !st.out_free);
        if (cmd.scan_step && st.scan_last) begin
          state_next = S_TICK_END;
        end
      end
      S_TICK_END: begin
        if (st.out_free) begin
          cmd.tick_commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/twtp_dp.sv */
module twtp_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [twtp_pkg::PADDR_W-1:0]           paddr,
  input  logic [twtp_pkg::PDATA_W-1:0]           pwdata,
  output logic [twtp_pkg::PDATA_W-1:0]           prdata,
  input  logic [twtp_pkg::REQ_W-1:0]             req_type,
  input  logic signed [twtp_pkg::TIMEOUT_W-1:0]  timeout,
  input  logic [twtp_pkg::HANDLE_W-1:0]          timer_handle,
  input  logic [twtp_pkg::TAG_W-1:0]             user_tag,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [twtp_pkg::STATUS_W-1:0]          status,
  output logic [twtp_pkg::HANDLE_W-1:0]          handle_out,
  output logic [twtp_pkg::TAG_W-1:0]             tag_out,
  output logic [twtp_pkg::SLOT_OUT_W-1:0]        slot_out,
  output logic                                   last,
  input  twtp_pkg::ctl_cmd_t                     cmd,
  output twtp_pkg::dp_stat_t                     st
);

  logic [twtp_pkg::SI_W-1:0]      slot_interval;
  logic [twtp_pkg::SLOT_W-1:0]    current_slot;
  logic [twtp_pkg::TIMERS-1:0]    valid;
  logic [twtp_pkg::TIMEOUT_W-1:0] dq;
  logic [twtp_pkg::SI_W-1:0]      rem;
  logic [twtp_pkg::DCNT_W-1:0]    div_cnt;
  logic [twtp_pkg::IDX_W-1:0]     find_idx;
  logic                           find_done;
  logic                           found;
  logic [twtp_pkg::TAG_W-1:0]     add_tag;
  logic [twtp_pkg::IDX_W-1:0]     scan_idx;
  logic                           pend_valid;
  logic [twtp_pkg::IDX_W-1:0]     pend_idx;
  logic [twtp_pkg::TAG_W-1:0]     pend_tag;

  logic [twtp_pkg::SI_W-1:0]      si_eff;
  logic [twtp_pkg::SI_W:0]        shifted;
  logic                           ge;
  logic                           div_done;
  logic [twtp_pkg::SLOT_W-1:0]    ticks_low;
  logic [twtp_pkg::SLOT_W-1:0]    add_slot;
  logic [twtp_pkg::SLOT_W-1:0]    behind;
  logic [twtp_pkg::IDX_W-1:0]     h_idx;
  logic                           bad;
  logic                           out_free;
  logic                           match;
  logic                           cfg_wr;

  logic                           ram_we_slot;
  logic                           ram_we_tag;
  logic [twtp_pkg::IDX_W-1:0]     ram_waddr;
  logic [twtp_pkg::SLOT_W-1:0]    ram_wslot;
  logic [twtp_pkg::IDX_W-1:0]     ram_raddr;
  logic [twtp_pkg::SLOT_W-1:0]    slot_rdata;
  logic [twtp_pkg::TAG_W-1:0]     tag_rdata;

  logic                           out_load;
  logic [twtp_pkg::STATUS_W-1:0]  status_next;
  logic [twtp_pkg::HANDLE_W-1:0]  handle_next;
  logic [twtp_pkg::TAG_W-1:0]     tag_next;
  logic [twtp_pkg::SLOT_OUT_W-1:0] slot_next;
  logic                           last_next;

  // Config register
  assign cfg_wr = psel && penable && pwrite && (paddr == twtp_pkg::ADDR_SLOT_INTERVAL);
  assign prdata = (paddr == twtp_pkg::ADDR_SLOT_INTERVAL) ?
                  twtp_pkg::PDATA_W'(slot_interval) : '0;
  assign si_eff = (slot_interval == '0) ? twtp_pkg::SI_W'(1) : slot_interval;

  // Restoring divider step
  assign shifted  = {rem, dq[twtp_pkg::TIMEOUT_W-1]};
  assign ge       = shifted >= {1'b0, si_eff};
  assign div_done = div_cnt == twtp_pkg::DCNT_W'(twtp_pkg::DIV_STEPS);

  // Slot arithmetic wraps in SLOT_W bits
  assign ticks_low = (dq == '0) ? twtp_pkg::SLOT_W'(1) : dq[twtp_pkg::SLOT_W-1:0];
  assign add_slot  = current_slot - twtp_pkg::SLOT_W'(1) + ticks_low;
  assign behind    = current_slot - twtp_pkg::SLOT_W'(1);

  assign h_idx = timer_handle[twtp_pkg::IDX_W-1:0];
  assign bad   = ({1'b0, timer_handle} >= (twtp_pkg::HANDLE_W+1)'(twtp_pkg::TIMERS))
                 || !valid[h_idx];

  assign out_free = !out_valid || !out_stall;
  assign match    = valid[scan_idx] && (slot_rdata == current_slot);

  assign st.req        = req_type;
  assign st.neg        = timeout[twtp_pkg::TIMEOUT_W-1];
  assign st.add_done   = div_done && find_done;
  assign st.match      = match;
  assign st.pend_valid = pend_valid;
  assign st.scan_last  = scan_idx == twtp_pkg::IDX_W'(twtp_pkg::TIMERS - 1);
  assign st.out_free   = out_free;

  // Slot and tag stores
  assign ram_we_tag  = cmd.add_commit && found;
  assign ram_we_slot = ram_we_tag ||
                       (cmd.imm_commit && (req_type == twtp_pkg::REQ_REFRESH) && !bad);
  assign ram_waddr   = cmd.add_commit ? find_idx : h_idx;
  assign ram_wslot   = cmd.add_commit ? add_slot : behind;
  assign ram_raddr   = cmd.scan_step ? scan_idx + twtp_pkg::IDX_W'(1) : scan_idx;

  twtp_ram #(.WIDTH(twtp_pkg::SLOT_W), .DEPTH(twtp_pkg::TIMERS)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we_slot),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .raddr (ram_raddr),
    .rdata (slot_rdata)
  );

  twtp_ram #(.WIDTH(twtp_pkg::TAG_W), .DEPTH(twtp_pkg::TIMERS)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we_tag),
    .waddr (ram_waddr),
    .wdata (add_tag),
    .raddr (ram_raddr),
    .rdata (tag_rdata)
  );

  // Select the next result
  always_comb begin
    out_load    = 1'b0;
    status_next = twtp_pkg::ST_TICK_NONE;
    handle_next = '0;
    tag_next    = '0;
    slot_next   = '0;
    last_next   = 1'b1;
    if (cmd.imm_commit) begin
      out_load = 1'b1;
      case (req_type)
        twtp_pkg::REQ_ADD: status_next = twtp_pkg::ST_NEGATIVE;
        twtp_pkg::REQ_DELETE: begin
          status_next = bad ? twtp_pkg::ST_BAD : twtp_pkg::ST_REMOVED;
          handle_next = timer_handle;
        end
        default: begin
          status_next = bad ? twtp_pkg::ST_BAD : twtp_pkg::ST_REFRESHED;
          handle_next = timer_handle;
          slot_next   = bad ? '0 : twtp_pkg::SLOT_OUT_W'(behind);
        end
      endcase
    end else if (cmd.add_commit) begin
      out_load = 1'b1;
      if (found) begin
        status_next = twtp_pkg::ST_ADDED;
        handle_next = twtp_pkg::HANDLE_W'(find_idx);
        slot_next   = twtp_pkg::SLOT_OUT_W'(add_slot);
      end else begin
        status_next = twtp_pkg::ST_FULL;
      end
    end else if (cmd.scan_step && match && pend_valid) begin
      out_load    = 1'b1;
      status_next = twtp_pkg::ST_EXPIRED;
      handle_next = twtp_pkg::HANDLE_W'(pend_idx);
      tag_next    = pend_tag;
      slot_next   = twtp_pkg::SLOT_OUT_W'(current_slot);
      last_next   = 1'b0;
    end else if (cmd.tick_commit) begin
      out_load  = 1'b1;
      slot_next = twtp_pkg::SLOT_OUT_W'(current_slot);
      if (pend_valid) begin
        status_next = twtp_pkg::ST_EXPIRED;
        handle_next = twtp_pkg::HANDLE_W'(pend_idx);
        tag_next    = pend_tag;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_interval <= twtp_pkg::SI_W'(1);
      current_slot  <= '0;
      valid         <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      find_done     <= 1'b0;
      found         <= 1'b0;
      div_cnt       <= '0;
      find_idx      <= '0;
      scan_idx      <= '0;
    end else begin
      if (cfg_wr) begin
        slot_interval <= pwdata[twtp_pkg::SI_W-1:0];
      end
      out_valid <= out_load || (out_valid && out_stall);

      if (cmd.add_start) begin
        div_cnt   <= '0;
        find_idx  <= '0;
        find_done <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.add_step) begin
        if (!div_done) begin
          div_cnt <= div_cnt + twtp_pkg::DCNT_W'(1);
        end
        // walk the pool for the lowest free handle
        if (!find_done) begin
          if (!valid[find_idx]) begin
            find_done <= 1'b1;
            found     <= 1'b1;
          end else if (find_idx == twtp_pkg::IDX_W'(twtp_pkg::TIMERS - 1)) begin
            find_done <= 1'b1;
          end else begin
            find_idx <= find_idx + twtp_pkg::IDX_W'(1);
          end
        end
      end

      if (cmd.add_commit && found) begin
        valid[find_idx] <= 1'b1;
      end
      if (cmd.imm_commit && (req_type == twtp_pkg::REQ_DELETE) && !bad) begin
        valid[h_idx] <= 1'b0;
      end

      if (cmd.tick_start) begin
        scan_idx   <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + twtp_pkg::IDX_W'(1);
        if (match) begin
          valid[scan_idx] <= 1'b0;
          pend_valid      <= 1'b1;
        end
      end
      if (cmd.tick_commit) begin
        pend_valid   <= 1'b0;
        current_slot <= current_slot + twtp_pkg::SLOT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.add_start) begin
      dq      <= $unsigned(timeout);
      rem     <= '0;
      add_tag <= user_tag;
    end else if (cmd.add_step && !div_done) begin
      dq  <= {dq[twtp_pkg::TIMEOUT_W-2:0], ge};
      rem <= ge ? shifted[twtp_pkg::SI_W-1:0] - si_eff : shifted[twtp_pkg::SI_W-1:0];
    end
    if (cmd.scan_step && match) begin
      pend_idx <= scan_idx;
      pend_tag <= tag_rdata;
    end
    if (out_load) begin
      status     <= status_next;
      handle_out <= handle_next;
      tag_out    <= tag_next;
      slot_out   <= slot_next;
      last       <= last_next;
    end
  end

endmodule

/* rtl/twtp_checker.sv */
module twtp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [twtp_pkg::STATUS_W-1:0]     status,
  input logic [twtp_pkg::HANDLE_W-1:0]     handle_out,
  input logic [twtp_pkg::TAG_W-1:0]        tag_out,
  input logic [twtp_pkg::SLOT_OUT_W-1:0]   slot_out,
  input logic                              last
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(handle_out)
      && $stable(tag_out) && $stable(last))
    else $error("stalled result changed");

  // Only an expiry can be followed by more results of the same request
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != twtp_pkg::ST_EXPIRED) |-> last)
    else $error("non-expiry result without last");

  // Tags travel only with expiries
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != twtp_pkg::ST_EXPIRED) |-> (tag_out == '0))
    else $error("tag on non-expiry result");

  // Delete and error results carry no slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == twtp_pkg::ST_REMOVED) || (status == twtp_pkg::ST_NEGATIVE)
      || (status == twtp_pkg::ST_FULL) || (status == twtp_pkg::ST_BAD))
      |-> (slot_out == '0))
    else $error("slot on delete or error result");

endmodule

bind timing_wheel_timer_pool_core twtp_checker u_twtp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .handle_out (handle_out),
  .tag_out    (tag_out),
  .slot_out   (slot_out),
  .last       (last)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [twtp_pkg::STATUS_W-1:0]   st;
    logic [twtp_pkg::HANDLE_W-1:0]   hnd;
    logic [twtp_pkg::TAG_W-1:0]      tag;
    logic [twtp_pkg::SLOT_OUT_W-1:0] slot;
    logic                            lst;
  } timer_result_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [twtp_pkg::PADDR_W-1:0] paddr;
  logic [twtp_pkg::PDATA_W-1:0] pwdata;
  logic [twtp_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [twtp_pkg::REQ_W-1:0] req_type;
  logic signed [twtp_pkg::TIMEOUT_W-1:0] timeout;
  logic [twtp_pkg::HANDLE_W-1:0] timer_handle;
  logic [twtp_pkg::TAG_W-1:0] user_tag;
  logic out_valid, out_stall;
  logic [twtp_pkg::STATUS_W-1:0] status;
  logic [twtp_pkg::HANDLE_W-1:0] handle_out;
  logic [twtp_pkg::TAG_W-1:0] tag_out;
  logic [twtp_pkg::SLOT_OUT_W-1:0] slot_out;
  logic last;

  // Wheel shadow state
  logic [15:0]                 wheel_interval;
  logic [twtp_pkg::SLOT_W-1:0] wheel_pos;
  logic                        live[twtp_pkg::TIMERS];
  logic [twtp_pkg::SLOT_W-1:0] live_slot[twtp_pkg::TIMERS];
  logic [twtp_pkg::TAG_W-1:0]  live_tag[twtp_pkg::TIMERS];

  timer_result_t pending_results[$];

  int idle_pct;
  int stall_pct;
  int cycles;
  int errors;
  int items_sent;
  int results_seen;
  int expiries_seen;
  int full_seen;

  timing_wheel_timer_pool_core uut (.*);

  // Clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Randomized receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report(input string what, input timer_result_t want,
                        input timer_result_t got);
    $display({"Mismatch %s at cycle %0d: want st=%0d h=%0d tag=%h slot=%0d last=%0d, ",
              "got st=%0d h=%0d tag=%h slot=%0d last=%0d"},
             what, cycles, want.st, want.hnd, want.tag, want.slot, want.lst,
             got.st, got.hnd, got.tag, got.slot, got.lst);
    errors++;
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, handle_out, tag_out, slot_out, last};
      results_seen++;
      if (status == twtp_pkg::ST_EXPIRED) expiries_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.st != want.st) report("status", want, got);
        else if (got.hnd != want.hnd) report("handle", want, got);
        else if (got.tag != want.tag) report("tag", want, got);
        else if (got.slot != want.slot) report("slot", want, got);
        else if (got.lst != want.lst) report("last", want, got);
      end
    end
  end

  // Work out the results of one accepted request and update the shadow wheel
  function automatic void predict_request(input logic [twtp_pkg::REQ_W-1:0] rq,
                                          input logic [31:0] to,
                                          input logic [twtp_pkg::HANDLE_W-1:0] h,
                                          input logic [twtp_pkg::TAG_W-1:0] tg);
    logic [31:0] si;
    logic [31:0] ticks;
    logic [twtp_pkg::SLOT_W-1:0] target;
    int free_idx;
    int n;
    timer_result_t r;
    si = (wheel_interval == 0) ? 32'd1 : {16'd0, wheel_interval};
    free_idx = -1;
    n = 0;
    case (rq)
      twtp_pkg::REQ_ADD: begin
        if (to[31]) begin
          pending_results.push_back('{twtp_pkg::ST_NEGATIVE, '0, '0, '0, 1'b1});
        end else begin
          ticks = (to < si) ? 32'd1 : to / si;
          for (int i = twtp_pkg::TIMERS - 1; i >= 0; i--) if (!live[i]) free_idx = i;
          if (free_idx < 0) begin
            full_seen++;
            pending_results.push_back('{twtp_pkg::ST_FULL, '0, '0, '0, 1'b1});
          end else begin
            target = wheel_pos - twtp_pkg::SLOT_W'(1) + ticks[twtp_pkg::SLOT_W-1:0];
            live[free_idx] = 1'b1;
            live_slot[free_idx] = target;
            live_tag[free_idx] = tg;
            pending_results.push_back('{twtp_pkg::ST_ADDED,
                                        twtp_pkg::HANDLE_W'(free_idx), '0, target, 1'b1});
          end
        end
      end
      twtp_pkg::REQ_DELETE, twtp_pkg::REQ_REFRESH: begin
        if (!live[h]) begin
          pending_results.push_back('{twtp_pkg::ST_BAD, h, '0, '0, 1'b1});
        end else if (rq == twtp_pkg::REQ_DELETE) begin
          live[h] = 1'b0;
          pending_results.push_back('{twtp_pkg::ST_REMOVED, h, '0, '0, 1'b1});
        end else begin
          live_slot[h] = wheel_pos - twtp_pkg::SLOT_W'(1);
          pending_results.push_back('{twtp_pkg::ST_REFRESHED, h, '0, live_slot[h], 1'b1});
        end
      end
      default: begin
        for (int i = 0; i < twtp_pkg::TIMERS; i++) begin
          if (live[i] && live_slot[i] == wheel_pos) begin
            live[i] = 1'b0;
            pending_results.push_back('{twtp_pkg::ST_EXPIRED, twtp_pkg::HANDLE_W'(i),
                                        live_tag[i], wheel_pos, 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          pending_results.push_back('{twtp_pkg::ST_TICK_NONE, '0, '0, wheel_pos, 1'b1});
        end else begin
          r = pending_results.pop_back();
          r.lst = 1'b1;
          pending_results.push_back(r);
        end
        wheel_pos = wheel_pos + twtp_pkg::SLOT_W'(1);
      end
    endcase
  endfunction

  // Present one request, hold it until the transfer, then maybe go idle
  task automatic send_request(input logic [twtp_pkg::REQ_W-1:0] rq, input logic [31:0] to,
                              input logic [twtp_pkg::HANDLE_W-1:0] h,
                              input logic [twtp_pkg::TAG_W-1:0] tg);
    int gap;
    in_valid <= 1'b1;
    req_type <= rq;
    timeout <= to;
    timer_handle <= h;
    user_tag <= tg;
    do @(posedge clk); while (in_stall);
    predict_request(rq, to, h, tg);
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected result has arrived and the block settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_interval(input logic [31:0] val);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= twtp_pkg::ADDR_SLOT_INTERVAL;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    wheel_interval = val[15:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_timeout();
    logic [31:0] si;
    int sel;
    si = (wheel_interval == 0) ? 32'd1 : {16'd0, wheel_interval};
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 70) * si + $urandom_range(0, si - 1);
    if (sel < 8) return $urandom;
    if (sel == 8) return $urandom | 32'h8000_0000;
    return $urandom_range(0, si);
  endfunction

  function automatic logic [twtp_pkg::HANDLE_W-1:0] pick_handle();
    logic [twtp_pkg::HANDLE_W-1:0] cand[$];
    for (int i = 0; i < twtp_pkg::TIMERS; i++)
      if (live[i]) cand.push_back(twtp_pkg::HANDLE_W'(i));
    if (cand.size() == 0 || $urandom_range(0, 9) == 0)
      return twtp_pkg::HANDLE_W'($urandom_range(0, 63));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Extremes of every field and each corner case at unit interval
  task automatic test_directed();
    write_interval(32'd1);
    send_request(twtp_pkg::REQ_TICK, 0, 0, 0);
    send_request(twtp_pkg::REQ_ADD, 32'd0, 0, 16'hFFFF);
    send_request(twtp_pkg::REQ_ADD, 32'd1, 0, 16'h0000);
    send_request(twtp_pkg::REQ_ADD, 32'd5, 63, 16'hA5A5);
    send_request(twtp_pkg::REQ_ADD, 32'hFFFF_FFFF, 0, 16'h1234);
    send_request(twtp_pkg::REQ_ADD, 32'h8000_0000, 0, 16'h1234);
    send_request(twtp_pkg::REQ_ADD, 32'h7FFF_FFFF, 0, 16'h5A5A);
    send_request(twtp_pkg::REQ_ADD, 32'd64, 0, 16'h0F0F);
    send_request(twtp_pkg::REQ_DELETE, 0, 6'd1, 0);
    send_request(twtp_pkg::REQ_DELETE, 0, 6'd1, 0);
    send_request(twtp_pkg::REQ_REFRESH, 0, 6'd2, 0);
    send_request(twtp_pkg::REQ_REFRESH, 0, 6'd63, 16'hFFFF);
    send_request(twtp_pkg::REQ_DELETE, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    repeat (6) send_request(twtp_pkg::REQ_TICK, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_request(twtp_pkg::REQ_REFRESH, 0, 6'd0, 0);
    send_request(twtp_pkg::REQ_ADD, 32'd0, 0, 16'h8001);
    send_request(twtp_pkg::REQ_TICK, 0, 0, 0);
  endtask

  // Interval register at zero behaves as one, then the widest interval
  task automatic test_interval_extremes();
    write_interval(32'd0);
    send_request(twtp_pkg::REQ_ADD, 32'd3, 0, 16'h0003);
    send_request(twtp_pkg::REQ_ADD, 32'd0, 0, 16'h0004);
    repeat (4) send_request(twtp_pkg::REQ_TICK, 0, 0, 0);
    write_interval(32'd65535);
    send_request(twtp_pkg::REQ_ADD, 32'd65534, 0, 16'h0005);
    send_request(twtp_pkg::REQ_ADD, 32'd131070, 0, 16'h0006);
    send_request(twtp_pkg::REQ_ADD, 32'hFFFF_FFFF >> 1, 0, 16'h0007);
    repeat (3) send_request(twtp_pkg::REQ_TICK, 0, 0, 0);
  endtask

  // Fill the pool past capacity, then sweep the wheel once to empty it
  task automatic test_pool_full();
    write_interval(32'd3);
    repeat (twtp_pkg::TIMERS + 2)
      send_request(twtp_pkg::REQ_ADD, $urandom_range(0, 300), 0,
                   twtp_pkg::TAG_W'($urandom));
    repeat (twtp_pkg::SLOTS)
      send_request(twtp_pkg::REQ_TICK, $urandom, twtp_pkg::HANDLE_W'($urandom),
                   twtp_pkg::TAG_W'($urandom));
  endtask

  // Mostly well-formed traffic on live handles, with some noise
  task automatic test_random_mix(input int count, input logic [31:0] interval,
                                 input int ip, input int sp);
    int sel;
    write_interval(interval);
    idle_pct = ip;
    stall_pct = sp;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (k == count / 2) wait_drained();
      if (sel < 35)
        send_request(twtp_pkg::REQ_ADD, pick_timeout(), twtp_pkg::HANDLE_W'($urandom),
                     twtp_pkg::TAG_W'($urandom));
      else if (sel < 65)
        send_request(twtp_pkg::REQ_TICK, $urandom, twtp_pkg::HANDLE_W'($urandom),
                     twtp_pkg::TAG_W'($urandom));
      else if (sel < 80)
        send_request(twtp_pkg::REQ_DELETE, $urandom, pick_handle(),
                     twtp_pkg::TAG_W'($urandom));
      else if (sel < 95)
        send_request(twtp_pkg::REQ_REFRESH, $urandom, pick_handle(),
                     twtp_pkg::TAG_W'($urandom));
      else
        send_request(twtp_pkg::REQ_ADD, $urandom, twtp_pkg::HANDLE_W'($urandom),
                     twtp_pkg::TAG_W'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req_type = twtp_pkg::REQ_TICK;
    timeout = '0;
    timer_handle = '0;
    user_tag = '0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    expiries_seen = 0;
    full_seen = 0;
    wheel_interval = 16'd1;
    wheel_pos = '0;
    for (int i = 0; i < twtp_pkg::TIMERS; i++) live[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_interval_extremes();
    test_pool_full();
    test_random_mix(50, 32'd1, 0, 0);
    test_random_mix(50, 32'd7, 79, 0);
    test_random_mix(50, 32'd65535, 0, 79);
    test_random_mix(50, 32'd2, 9, 9);

    wait_drained();
    $display("Sent %0d requests, checked %0d results (%0d expiries, %0d pool-full rejects)",
             items_sent, results_seen, expiries_seen, full_seen);
    $display("Covered intervals 0, 1, 2, 3, 7 and 65535 under four idle/stall mixes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
